// ===== sv/pws_pkg.sv =====
package pws_pkg;

  localparam logic [46:0] UMAX        = {47{1'b1}};
  localparam logic [47:0] NEGCAP      = 48'h8000_0000_0000;
  localparam logic [47:0] Q_ONE       = 48'd65536;
  localparam logic [47:0] Q_FOUR      = 48'd262144;
  localparam logic [46:0] ALPHA_RESET = 47'd65536;

  localparam int DIV_LAT       = 64;
  localparam int MUL_LAT       = 3;
  localparam int SQRT_LAT      = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int SETTLE_CYCLES = 2 * MUL_LAT + DIV_LAT + 2;

  typedef struct packed {
    logic signed [47:0] normal_velocity;
    logic [46:0]        sound_speed;
    logic [46:0]        heat_cap_pressure;
    logic [46:0]        heat_cap_volume;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] velocity_prime;
    logic [46:0]        sound_prime;
    logic signed [47:0] wave_minus;
    logic signed [47:0] wave_mid;
    logic signed [47:0] wave_plus;
    logic               divide_fault;
  } out_item_t;

  typedef struct packed {
    logic signed [47:0] u;
    logic [47:0]        umag;
    logic [46:0]        c;
    logic [46:0]        cp;
    logic [46:0]        cv;
    logic               u_neg;
    logic               cv_zero;
    logic               fault;
  } work_t;

  typedef struct packed {
    logic [46:0] a2;
    logic [46:0] t2;
    logic [46:0] fr;
  } consts_t;

endpackage

// ===== sv/pws_mul.sv =====
module pws_mul import pws_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [47:0] a,
  input  logic [47:0] b,
  input  logic        sh17,
  input  logic        neg_cap,
  output logic [47:0] p
);

  logic [47:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [95:0] sum_r;
  logic [1:0]  mode1_r, mode2_r;
  logic [47:0] p_r;
  logic [95:0] shifted;
  logic [47:0] cap;

  always_comb begin
    shifted = mode2_r[1] ? (sum_r >> 17) : (sum_r >> 16);
    cap     = mode2_r[0] ? NEGCAP : {1'b0, UMAX};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r  <= 48'(a[23:0])  * 48'(b[23:0]);
      pp01_r  <= 48'(a[23:0])  * 48'(b[47:24]);
      pp10_r  <= 48'(a[47:24]) * 48'(b[23:0]);
      pp11_r  <= 48'(a[47:24]) * 48'(b[47:24]);
      mode1_r <= {sh17, neg_cap};
      sum_r   <= {pp11_r, 48'd0} + ({48'd0, pp01_r} << 24) + ({48'd0, pp10_r} << 24)
                 + {48'd0, pp00_r};
      mode2_r <= mode1_r;
      p_r     <= (shifted > {48'd0, cap}) ? cap : shifted[47:0];
    end
  end

  assign p = p_r;

endmodule

// ===== sv/pws_div.sv =====
module pws_div import pws_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [47:0] num,
  input  logic [46:0] den,
  output logic [47:0] quo
);

  logic [63:0] n_r   [DIV_LAT];
  logic [63:0] q_r   [DIV_LAT];
  logic [46:0] r_r   [DIV_LAT];
  logic [46:0] d_r   [DIV_LAT];
  logic [63:0] n_in  [DIV_LAT];
  logic [63:0] q_in  [DIV_LAT];
  logic [46:0] r_in  [DIV_LAT];
  logic [46:0] d_in  [DIV_LAT];
  logic [47:0] trial [DIV_LAT];
  logic        ge    [DIV_LAT];
  logic [63:0] q_full;

  always_comb begin
    n_in[0] = {num, 16'd0};
    q_in[0] = '0;
    r_in[0] = '0;
    d_in[0] = den;
    for (int k = 1; k < DIV_LAT; k++) begin
      n_in[k] = n_r[k-1];
      q_in[k] = q_r[k-1];
      r_in[k] = r_r[k-1];
      d_in[k] = d_r[k-1];
    end
    for (int k = 0; k < DIV_LAT; k++) begin
      trial[k] = {r_in[k], n_in[k][63]};
      ge[k]    = trial[k] >= {1'b0, d_in[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        n_r[k] <= {n_in[k][62:0], 1'b0};
        q_r[k] <= {q_in[k][62:0], ge[k]};
        r_r[k] <= ge[k] ? 47'(trial[k] - {1'b0, d_in[k]}) : trial[k][46:0];
        d_r[k] <= d_in[k];
      end
    end
  end

  assign q_full = q_r[DIV_LAT-1];
  assign quo    = (q_full > {16'd0, NEGCAP}) ? NEGCAP : q_full[47:0];

endmodule

// ===== sv/pws_sqrt.sv =====
module pws_sqrt import pws_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  output logic [31:0] root
);

  logic [63:0] x_r    [SQRT_LAT];
  logic [63:0] res_r  [SQRT_LAT];
  logic [63:0] x_in   [SQRT_LAT];
  logic [63:0] res_in [SQRT_LAT];
  logic [63:0] trial  [SQRT_LAT];
  logic [63:0] bitv   [SQRT_LAT];
  logic        ge     [SQRT_LAT];

  always_comb begin
    x_in[0]   = x;
    res_in[0] = '0;
    for (int k = 1; k < SQRT_LAT; k++) begin
      x_in[k]   = x_r[k-1];
      res_in[k] = res_r[k-1];
    end
    for (int k = 0; k < SQRT_LAT; k++) begin
      bitv[k]  = 64'd1 << (62 - 2 * k);
      trial[k] = res_in[k] + bitv[k];
      ge[k]    = x_in[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        x_r[k]   <= ge[k] ? x_in[k] - trial[k] : x_in[k];
        res_r[k] <= ge[k] ? (res_in[k] >> 1) + bitv[k] : res_in[k] >> 1;
      end
    end
  end

  assign root = res_r[SQRT_LAT-1][31:0];

endmodule

// ===== sv/pws_front.sv =====
module pws_front import pws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [46:0] cfg_wdata,
  output logic        q_valid,
  output work_t       q_head,
  input  logic        q_pop,
  output consts_t     consts
);

  localparam int QA   = $clog2(QUEUE_DEPTH);
  localparam int SETW = $clog2(SETTLE_CYCLES + 1);

  logic [46:0]   alpha_r;
  logic [SETW-1:0] settle_r;
  logic [46:0]   a_eff;
  logic [47:0]   a2_raw, r_q, fr_q, t_mag, t2_raw;
  logic [46:0]   a2;
  work_t         mem_r [QUEUE_DEPTH];
  logic [QA-1:0] wr_ptr_r, rd_ptr_r;
  logic [QA:0]   count_r;
  logic          push, full, busy;
  work_t         w_in;

  assign a_eff = (alpha_r == '0) ? 47'd1 : alpha_r;
  assign a2    = (a2_raw == '0) ? 47'd1 : a2_raw[46:0];
  assign t_mag = (r_q >= Q_ONE) ? r_q - Q_ONE : Q_ONE - r_q;

  pws_mul u_mul_a2 (
    .clk(clk), .en(1'b1), .a({1'b0, a_eff}), .b({1'b0, a_eff}),
    .sh17(1'b0), .neg_cap(1'b0), .p(a2_raw)
  );

  pws_div u_div_r (.clk(clk), .en(1'b1), .num(Q_ONE), .den(a2), .quo(r_q));

  pws_div u_div_fr (.clk(clk), .en(1'b1), .num(Q_FOUR), .den(a2), .quo(fr_q));

  pws_mul u_mul_t2 (
    .clk(clk), .en(1'b1), .a(t_mag), .b(t_mag),
    .sh17(1'b0), .neg_cap(1'b0), .p(t2_raw)
  );

  always_comb begin
    consts.a2 = a2;
    consts.t2 = t2_raw[46:0];
    consts.fr = (fr_q > {1'b0, UMAX}) ? UMAX : fr_q[46:0];
  end

  always_comb begin
    w_in.u       = in_data.normal_velocity;
    w_in.u_neg   = in_data.normal_velocity[47];
    w_in.umag    = in_data.normal_velocity[47] ? 48'(-in_data.normal_velocity)
                                               : 48'(in_data.normal_velocity);
    w_in.c       = in_data.sound_speed;
    w_in.cp      = in_data.heat_cap_pressure;
    w_in.cv      = in_data.heat_cap_volume;
    w_in.cv_zero = in_data.heat_cap_volume == '0;
    w_in.fault   = (in_data.heat_cap_volume == '0) || (in_data.sound_speed == '0);
  end

  assign busy     = settle_r != '0;
  assign full     = count_r == (QA+1)'(QUEUE_DEPTH);
  assign in_stall = busy || full;
  assign push     = in_valid && !in_stall;
  assign q_valid  = count_r != '0;
  assign q_head   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= ALPHA_RESET;
      settle_r <= SETW'(SETTLE_CYCLES);
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_we) begin
        alpha_r  <= cfg_wdata;
        settle_r <= SETW'(SETTLE_CYCLES);
      end else if (busy) begin
        settle_r <= settle_r - 1'b1;
      end
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + {{QA{1'b0}}, push} - {{QA{1'b0}}, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= w_in;
    end
  end

endmodule

// ===== sv/pws_back.sv =====
module pws_back import pws_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  work_t     q_head,
  output logic      q_pop,
  input  consts_t   consts,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int T_END  = 2 * DIV_LAT + MUL_LAT;
  localparam int T_SP   = DIV_LAT + 3 * MUL_LAT + SQRT_LAT;
  localparam int SP_DLY = T_END - T_SP - MUL_LAT;

  localparam logic signed [49:0] SMAX50 = $signed({3'b000, UMAX});
  localparam logic signed [49:0] SMIN50 = -$signed({2'b00, NEGCAP});

  typedef struct packed {
    logic signed [47:0] u;
    logic [47:0]        umag;
    logic [46:0]        c;
    logic               u_neg;
    logic               cv_zero;
    logic               fault;
  } side_t;

  typedef struct packed {
    logic [46:0] gp1;
    logic        gm1_neg;
  } mid_t;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > SMAX50) r = $signed({1'b0, UMAX});
    else if (v < SMIN50) r = $signed(NEGCAP);
    else r = v[47:0];
    return r;
  endfunction

  side_t       side_r [T_END];
  logic        vld_r  [T_END];
  mid_t        mid_r  [DIV_LAT];
  logic [46:0] m2_d   [MUL_LAT];
  logic        fneg_d [MUL_LAT];
  logic [46:0] sp_d   [SP_DLY];
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic               en;
  side_t              side_in, s_d, s_end;
  mid_t               mid_in, mid_q;
  logic [47:0]        qg, qm, qq, g2, m2, s1, s, sp_raw, vp_mag;
  logic [31:0]        root;
  logic [46:0]        g, rad, sp_final;
  logic [47:0]        gm1_mag, gp1_sum, mm, qcap, fac_mag, vp_bits;
  logic [48:0]        rad_sum;
  logic signed [49:0] qs50, fac50, vp50, sp50;
  logic               fac_neg, vp_neg;
  logic signed [47:0] vp_final;
  out_item_t          res;

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && q_valid;

  always_comb begin
    side_in.u       = q_head.u;
    side_in.umag    = q_head.umag;
    side_in.c       = q_head.c;
    side_in.u_neg   = q_head.u_neg;
    side_in.cv_zero = q_head.cv_zero;
    side_in.fault   = q_head.fault;
  end

  pws_div u_div_g (
    .clk(clk), .en(en), .num({1'b0, q_head.cp}), .den(q_head.cv), .quo(qg)
  );

  pws_div u_div_m (
    .clk(clk), .en(en), .num(q_head.umag), .den(q_head.c), .quo(qm)
  );

  always_comb begin
    s_d            = side_r[DIV_LAT-1];
    g              = (qg > {1'b0, UMAX}) ? UMAX : qg[46:0];
    mid_in.gm1_neg = {1'b0, g} < Q_ONE;
    gm1_mag        = mid_in.gm1_neg ? Q_ONE - {1'b0, g} : {1'b0, g} - Q_ONE;
    gp1_sum        = {1'b0, g} + Q_ONE;
    mid_in.gp1     = (gp1_sum > {1'b0, UMAX}) ? UMAX : gp1_sum[46:0];
    mm             = s_d.u_neg ? qm : ((qm > {1'b0, UMAX}) ? {1'b0, UMAX} : qm);
  end

  pws_div u_div_q (.clk(clk), .en(en), .num(gm1_mag), .den(consts.a2), .quo(qq));

  pws_mul u_mul_g2 (
    .clk(clk), .en(en), .a(gm1_mag), .b(gm1_mag), .sh17(1'b0), .neg_cap(1'b0), .p(g2)
  );

  pws_mul u_mul_m2 (
    .clk(clk), .en(en), .a(mm), .b(mm), .sh17(1'b0), .neg_cap(1'b0), .p(m2)
  );

  pws_mul u_mul_s1 (
    .clk(clk), .en(en), .a(g2), .b({1'b0, consts.t2}), .sh17(1'b0), .neg_cap(1'b0),
    .p(s1)
  );

  pws_mul u_mul_s (
    .clk(clk), .en(en), .a(s1), .b({1'b0, m2_d[MUL_LAT-1]}), .sh17(1'b0),
    .neg_cap(1'b0), .p(s)
  );

  always_comb begin
    rad_sum = {1'b0, s} + {2'b00, consts.fr};
    rad     = (rad_sum > {2'b00, UMAX}) ? UMAX : rad_sum[46:0];
  end

  pws_sqrt u_sqrt (.clk(clk), .en(en), .x({1'b0, rad, 16'd0}), .root(root));

  pws_mul u_mul_sp (
    .clk(clk), .en(en), .a({1'b0, side_r[T_SP-1].c}), .b({16'd0, root}),
    .sh17(1'b1), .neg_cap(1'b0), .p(sp_raw)
  );

  always_comb begin
    mid_q   = mid_r[DIV_LAT-1];
    qcap    = (qq > {1'b0, UMAX}) ? {1'b0, UMAX} : qq;
    qs50    = mid_q.gm1_neg ? -$signed({2'b00, qq}) : $signed({2'b00, qcap});
    fac50   = $signed({3'b000, mid_q.gp1}) - qs50;
    fac_neg = fac50 < 0;
    if (fac_neg) fac_mag = 48'(-fac50);
    else if (fac50 > SMAX50) fac_mag = {1'b0, UMAX};
    else fac_mag = fac50[47:0];
  end

  pws_mul u_mul_vp (
    .clk(clk), .en(en), .a(side_r[2*DIV_LAT-1].umag), .b(fac_mag), .sh17(1'b1),
    .neg_cap(1'b1), .p(vp_mag)
  );

  always_comb begin
    s_end   = side_r[T_END-1];
    vp_neg  = s_end.u_neg ^ fneg_d[MUL_LAT-1];
    if (vp_neg) vp_bits = 48'(-vp_mag);
    else if (vp_mag > {1'b0, UMAX}) vp_bits = {1'b0, UMAX};
    else vp_bits = vp_mag;
    if (!s_end.cv_zero) vp_final = $signed(vp_bits);
    else if (s_end.u_neg) vp_final = $signed(NEGCAP);
    else if (s_end.u == '0) vp_final = '0;
    else vp_final = $signed({1'b0, UMAX});
    sp_final = s_end.fault ? UMAX : sp_d[SP_DLY-1];
    vp50     = $signed({{2{vp_final[47]}}, vp_final});
    sp50     = $signed({3'b000, sp_final});
    res.velocity_prime = vp_final;
    res.sound_prime    = sp_final;
    res.wave_minus     = sat48(vp50 - sp50);
    res.wave_mid       = s_end.u;
    res.wave_plus      = sat48(vp50 + sp50);
    res.divide_fault   = s_end.fault;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      mid_r[0]  <= mid_in;
      m2_d[0]   <= m2[46:0];
      fneg_d[0] <= fac_neg;
      sp_d[0]   <= sp_raw[46:0];
      for (int k = 1; k < T_END; k++) side_r[k] <= side_r[k-1];
      for (int k = 1; k < DIV_LAT; k++) mid_r[k] <= mid_r[k-1];
      for (int k = 1; k < MUL_LAT; k++) begin
        m2_d[k]   <= m2_d[k-1];
        fneg_d[k] <= fneg_d[k-1];
      end
      for (int k = 1; k < SP_DLY; k++) sp_d[k] <= sp_d[k-1];
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int k = 0; k < T_END; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= q_valid;
      for (int k = 1; k < T_END; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[T_END-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/preconditioned_wave_speeds.sv =====
// Preconditioned acoustic wave speeds, one boundary face per request.
// Input channel in_valid/in_stall/in_data carries u, c, cp and cv; the
// result channel out_valid/out_stall/out_data carries u', c', u'-c', u,
// u'+c' and the divide fault flag. cfg_we/cfg_wdata writes alpha.
// A request is taken when valid is high and stall is low.
// Throughput: one request per cycle when not stalled, set by the fully
// pipelined dividers (64 stages), square root (32 stages) and multipliers
// (3 stages). From acceptance, a request waits in the input queue, then
// passes the two dividers and one multiplier on the velocity path
// (131 stages) and the output register before out_valid rises.
// A stall on the result side freezes the whole back pipeline; the input
// queue keeps taking requests until it holds four.
// Reset loads alpha with 1.0 and holds in_stall high while the
// alpha-derived constants settle; every configuration write does
// the same.
module preconditioned_wave_speeds import pws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [46:0] cfg_wdata
);

  logic    q_valid, q_pop;
  work_t   q_head;
  consts_t consts;

  pws_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop), .consts(consts)
  );

  pws_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .consts(consts), .out_stall(out_stall), .out_valid(out_valid),
    .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_fault_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_fault |-> out_data.sound_prime == UMAX)
    else $error("fault result without saturated sound speed");

  a_wave_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.wave_minus <= out_data.wave_plus)
    else $error("wave_minus above wave_plus");

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input taken right after configuration write");
`endif

endmodule
